@@ rtl/ame_pkg.sv @@
`default_nettype none
package ame_pkg;
   localparam int MemDepth = 1024;
   localparam int WordBits = 32;
   localparam int AddrBits = $clog2(MemDepth);
   localparam int CntBits  = $clog2(WordBits + 1);

   localparam logic [4:0] OP_AC_MQ   = 5'd1;
   localparam logic [4:0] OP_MQ_M    = 5'd2;
   localparam logic [4:0] OP_ST      = 5'd3;
   localparam logic [4:0] OP_LD      = 5'd4;
   localparam logic [4:0] OP_LD_NEG  = 5'd5;
   localparam logic [4:0] OP_LD_ABS  = 5'd6;
   localparam logic [4:0] OP_LD_NABS = 5'd7;
   localparam logic [4:0] OP_JMP     = 5'd8;
   localparam logic [4:0] OP_JGE     = 5'd9;
   localparam logic [4:0] OP_ADD     = 5'd10;
   localparam logic [4:0] OP_ADD_ABS = 5'd11;
   localparam logic [4:0] OP_SUB     = 5'd12;
   localparam logic [4:0] OP_SUB_ABS = 5'd13;
   localparam logic [4:0] OP_MUL     = 5'd14;
   localparam logic [4:0] OP_DIV     = 5'd15;
   localparam logic [4:0] OP_SHL     = 5'd16;
   localparam logic [4:0] OP_SHR     = 5'd17;

   typedef struct packed {
      logic               action;
      logic [4:0]         opcode;
      logic [9:0]         address;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] acc;
      logic signed [31:0] mq;
      logic [9:0]         next_pc;
      logic               div_by_zero;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/accumulator_machine_execute_top.sv @@
// Preload writes memory in S_READ, then goes to S_OUT; other instructions pass through
// S_READ and S_EXEC; multiply and divide (unless the divisor is zero) then go through one
// shared shift/add-subtract unit in S_ITER, one bit a cycle, and S_FIN. One item at a time:
// the next item is taken the cycle after the result leaves. After reset a clearing pass
// zeroes every memory word while req_stall is high. Synchronous active-high reset.
`default_nettype none
module accumulator_machine_execute_top (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire ame_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output ame_pkg::rsp_type     rsp_data
);
   import ame_pkg::*;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_ITER, S_FIN, S_OUT}
      state_type;

   state_type              state_ff;
   logic [AddrBits:0]      clr_ff;
   logic [WordBits-1:0]    mem [MemDepth];
   logic [WordBits-1:0]    rd_ff;
   req_type                req_ff;
   logic [WordBits-1:0]    ac_ff, mq_ff;
   logic [AddrBits-1:0]    pc_ff;
   logic                   dz_ff;
   logic [CntBits-1:0]     cnt_ff;
   logic [WordBits-1:0]    p_ff, q_ff, d_ff;
   logic                   qn_ff, rn_ff;

   logic                   mem_we;
   logic [AddrBits-1:0]    mem_wa;
   logic [WordBits-1:0]    mem_wd;
   logic [WordBits-1:0]    m_abs, m_neg, rem_sh, diff;
   logic [WordBits:0]      sub_w;
   logic                   is_mul;

   assign m_neg  = WordBits'(0) - rd_ff;
   assign m_abs  = rd_ff[WordBits-1] ? m_neg : rd_ff;
   assign is_mul = (req_ff.opcode == OP_MUL);
   assign rem_sh = {p_ff[WordBits-2:0], q_ff[WordBits-1]};
   assign sub_w  = {1'b0, rem_sh} - {1'b0, d_ff};
   assign diff   = sub_w[WordBits-1:0];

   always_comb begin
      mem_we = 1'b0;
      mem_wa = req_ff.address[AddrBits-1:0];
      mem_wd = WordBits'(req_ff.write_value);
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff[AddrBits-1:0];
         mem_wd = '0;
      end else if (state_ff == S_READ && req_ff.action) begin
         mem_we = 1'b1;
      end else if (state_ff == S_EXEC && !req_ff.action && req_ff.opcode == OP_ST) begin
         mem_we = 1'b1;
         mem_wd = ac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[req_ff.address[AddrBits-1:0]];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data.acc = 32'(signed'(ac_ff));
   assign rsp_data.mq  = 32'(signed'(mq_ff));
   assign rsp_data.next_pc = 10'(pc_ff);
   assign rsp_data.div_by_zero = dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ac_ff    <= '0;
         mq_ff    <= '0;
         pc_ff    <= '0;
         dz_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AddrBits+1)'(MemDepth - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               dz_ff    <= 1'b0;
               state_ff <= req_ff.action ? S_OUT : S_EXEC;
            end
            S_EXEC: begin
               pc_ff    <= pc_ff + 1'b1;
               state_ff <= S_OUT;
               case (req_ff.opcode)
                  OP_AC_MQ:   ac_ff <= mq_ff;
                  OP_MQ_M:    mq_ff <= rd_ff;
                  OP_LD:      ac_ff <= rd_ff;
                  OP_LD_NEG:  ac_ff <= m_neg;
                  OP_LD_ABS:  ac_ff <= m_abs;
                  OP_LD_NABS: ac_ff <= WordBits'(0) - m_abs;
                  OP_JMP:     pc_ff <= req_ff.address[AddrBits-1:0];
                  OP_JGE: if (!ac_ff[WordBits-1]) pc_ff <= req_ff.address[AddrBits-1:0];
                  OP_ADD:     ac_ff <= ac_ff + rd_ff;
                  OP_ADD_ABS: ac_ff <= ac_ff + m_abs;
                  OP_SUB:     ac_ff <= ac_ff - rd_ff;
                  OP_SUB_ABS: ac_ff <= ac_ff - m_abs;
                  OP_SHL:     ac_ff <= {ac_ff[WordBits-2:0], 1'b0};
                  OP_SHR:     ac_ff <= {ac_ff[WordBits-1], ac_ff[WordBits-1:1]} +
                                       WordBits'(ac_ff[WordBits-1] & ac_ff[0]);
                  OP_MUL: begin
                     p_ff <= '0; q_ff <= mq_ff; d_ff <= rd_ff;
                     cnt_ff <= '0; state_ff <= S_ITER;
                  end
                  OP_DIV: begin
                     if (rd_ff == '0) begin
                        dz_ff <= 1'b1;
                     end else begin
                        p_ff  <= '0;
                        q_ff  <= ac_ff[WordBits-1] ? WordBits'(0) - ac_ff : ac_ff;
                        d_ff  <= m_abs;
                        qn_ff <= ac_ff[WordBits-1] ^ rd_ff[WordBits-1];
                        rn_ff <= ac_ff[WordBits-1];
                        cnt_ff <= '0; state_ff <= S_ITER;
                     end
                  end
                  default: ;
               endcase
            end
            S_ITER: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (is_mul) begin
                  // low word only: shift-add from the multiplier LSB
                  if (q_ff[0]) p_ff <= p_ff + d_ff;
                  q_ff <= q_ff >> 1;
                  d_ff <= {d_ff[WordBits-2:0], 1'b0};
               end else begin
                  if (!sub_w[WordBits]) begin
                     p_ff <= diff;
                     q_ff <= {q_ff[WordBits-2:0], 1'b1};
                  end else begin
                     p_ff <= rem_sh;
                     q_ff <= {q_ff[WordBits-2:0], 1'b0};
                  end
               end
               if (cnt_ff == CntBits'(WordBits - 1)) state_ff <= S_FIN;
            end
            S_FIN: begin
               if (is_mul) begin
                  ac_ff <= p_ff;
               end else begin
                  mq_ff <= qn_ff ? WordBits'(0) - q_ff : q_ff;
                  ac_ff <= rn_ff ? WordBits'(0) - p_ff : p_ff;
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("ready while result pending");
   a_dz_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_by_zero |-> !req_ff.action && req_ff.opcode == OP_DIV)
      else $error("div_by_zero without divide");
`endif
endmodule
`default_nettype wire
